[rtl/core/liu3_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// liu3_pkg
// Shared types and constants for the three-axis linear interpolation
// upsampler.
// ----------------------------------------------------------------------------
package liu3_pkg;

    // Width of the samples-per-update register and its value after reset.
    localparam int unsigned CFG_W     = 7;
    localparam logic [CFG_W-1:0] CFG_RESET = 7'd8;

    // One lane per position axis.
    localparam int unsigned NUM_AXES  = 3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_EMIT
    } t_state;

    // Sequencer to lanes.
    typedef struct packed {
        logic start;
        logic adv;
    } t_lane_ctl;

    // Sequencer to output stage.
    typedef struct packed {
        logic load;
        logic last;
    } t_merge_ctl;

endpackage

[rtl/core/linear_interp_upsampler_3axis_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_interp_upsampler_3axis_top
// Three-axis linear interpolation upsampler for Q16.16 position estimates.
// ----------------------------------------------------------------------------
// Each accepted item carries a new x/y/z position; the block keeps the
// previous one (zero after reset) and emits N items that walk from the old
// position towards the new one in equal steps of (new - old) / N, truncated
// toward zero, the final item being the exact new position with
// o_last_sample set. N is the samples-per-update register (reset value 8);
// a value of zero counts as one and a value above MAX_SAMPLES is clamped to
// MAX_SAMPLES. Write the register only while the block is idle. Each axis
// has its own lane holding a restoring divider that produces one quotient
// bit per cycle. After the accepting edge the lanes divide, apply the sign
// and hand over to the output side, which then presents the first output
// item; the remaining items follow one per cycle when the output is not
// stalled. The next item is taken once the final item of the previous one
// has been loaded into the output register.
// ----------------------------------------------------------------------------
module linear_interp_upsampler_3axis_top #(
    parameter int unsigned MAX_SAMPLES = 64,
    parameter int unsigned POS_WIDTH   = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Input channel
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic signed [POS_WIDTH-1:0]       i_pos_x,
    input  logic signed [POS_WIDTH-1:0]       i_pos_y,
    input  logic signed [POS_WIDTH-1:0]       i_pos_z,
    // Output channel
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic signed [POS_WIDTH-1:0]       o_out_x,
    output logic signed [POS_WIDTH-1:0]       o_out_y,
    output logic signed [POS_WIDTH-1:0]       o_out_z,
    output logic                              o_last_sample,
    // Configuration
    input  logic                              i_cfg_we,
    input  logic [liu3_pkg::CFG_W-1:0]        i_cfg_data
);

    localparam int unsigned CW = liu3_pkg::CFG_W;
    localparam int unsigned NA = liu3_pkg::NUM_AXES;
    localparam logic [CW+1:0] MAX_S = (CW+2)'(MAX_SAMPLES);

    liu3_pkg::t_state     r_state, n_state;
    logic [CW-1:0]        r_cfg;
    logic [CW-1:0]        r_n;
    logic [CW-1:0]        r_k;
    logic [CW-1:0]        n_eff;
    logic [NA-1:0][POS_WIDTH-1:0] r_prev;
    logic [NA-1:0][POS_WIDTH-1:0] pos_in;
    logic [NA-1:0][POS_WIDTH-1:0] lane_val;
    logic [NA-1:0][POS_WIDTH-1:0] out_val;
    logic [NA-1:0]        lane_busy;
    logic                 accept;
    logic                 merge_free;
    liu3_pkg::t_lane_ctl  lane_ctl;
    liu3_pkg::t_merge_ctl merge_ctl;

    assign pos_in = {i_pos_z, i_pos_y, i_pos_x};
    assign accept = i_in_valid && (r_state == liu3_pkg::ST_IDLE);
    assign o_in_stall = (r_state != liu3_pkg::ST_IDLE);

    // Effective sample count: zero means one, anything above the maximum
    // is held at the maximum. A clamped value is always below the register
    // range, so the truncation is safe.
    always_comb begin
        priority if (r_cfg == '0) begin
            n_eff = CW'(1);
        end else if ({2'b00, r_cfg} > MAX_S) begin
            n_eff = MAX_S[CW-1:0];
        end else begin
            n_eff = r_cfg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= liu3_pkg::CFG_RESET;
        end else if (i_cfg_we) begin
            r_cfg <= i_cfg_data;
        end
    end

    // The stored position is replaced as soon as an item is taken; the
    // lanes have already captured the old one at the same edge, and the
    // final output item reads the new one from here.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= '0;
        end else if (accept) begin
            r_prev <= pos_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= liu3_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_n <= n_eff;
            r_k <= CW'(1);
        end else if (merge_ctl.load && !merge_ctl.last) begin
            r_k <= r_k + 1'b1;
        end
    end

    always_comb begin
        n_state        = r_state;
        lane_ctl.start = 1'b0;
        lane_ctl.adv   = 1'b0;
        merge_ctl.load = 1'b0;
        merge_ctl.last = 1'b0;
        unique case (r_state)
            liu3_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    lane_ctl.start = 1'b1;
                    n_state        = liu3_pkg::ST_DIV;
                end
            end
            liu3_pkg::ST_DIV: begin
                if (lane_busy == '0) begin
                    n_state = liu3_pkg::ST_EMIT;
                end
            end
            liu3_pkg::ST_EMIT: begin
                if (merge_free) begin
                    merge_ctl.load = 1'b1;
                    merge_ctl.last = (r_k == r_n);
                    lane_ctl.adv   = (r_k != r_n);
                    if (r_k == r_n) begin
                        n_state = liu3_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = liu3_pkg::ST_IDLE;
            end
        endcase
    end

    for (genvar g = 0; g < NA; g++) begin : g_lane
        liu3_lane #(
            .POS_WIDTH (POS_WIDTH)
        ) u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (lane_ctl),
            .i_old   (r_prev[g]),
            .i_new   (pos_in[g]),
            .i_n     (n_eff),
            .o_busy  (lane_busy[g]),
            .o_next  (lane_val[g])
        );
    end

    liu3_merge #(
        .POS_WIDTH (POS_WIDTH)
    ) u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (merge_ctl),
        .i_lane_val  (lane_val),
        .i_final_val (r_prev),
        .i_out_stall (i_out_stall),
        .o_free      (merge_free),
        .o_out_valid (o_out_valid),
        .o_val       (out_val),
        .o_last      (o_last_sample)
    );

    assign o_out_x = out_val[0];
    assign o_out_y = out_val[1];
    assign o_out_z = out_val[2];

endmodule

[rtl/core/liu3_lane.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// liu3_lane
// One axis: divides the position difference by the sample count, one
// quotient bit per cycle, then steps an accumulator from the old position.
// ----------------------------------------------------------------------------
module liu3_lane #(
    parameter int unsigned POS_WIDTH = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  liu3_pkg::t_lane_ctl                i_ctl,
    input  logic signed [POS_WIDTH-1:0]        i_old,
    input  logic signed [POS_WIDTH-1:0]        i_new,
    input  logic [liu3_pkg::CFG_W-1:0]         i_n,
    output logic                               o_busy,
    output logic [POS_WIDTH-1:0]               o_next
);

    localparam int unsigned DW  = POS_WIDTH + 1;
    localparam int unsigned CW  = $clog2(DW + 1);
    localparam int unsigned RW  = liu3_pkg::CFG_W;

    logic signed [DW-1:0] diff;
    logic [DW-1:0]        mag;
    logic [RW:0]          trial;
    logic                 ge;
    logic [RW:0]          trial_sub;

    logic [DW-1:0]        r_quo;
    logic [RW-1:0]        r_rem;
    logic [RW-1:0]        r_div;
    logic                 r_neg;
    logic [CW-1:0]        r_cnt;
    logic                 r_busy;
    logic [DW-1:0]        r_acc;
    logic [DW-1:0]        r_step;

    assign diff      = DW'(i_new) - DW'(i_old);
    assign mag       = diff[DW-1] ? DW'(-diff) : DW'(diff);
    assign trial     = {r_rem, r_quo[DW-1]};
    assign ge        = trial >= {1'b0, r_div};
    assign trial_sub = trial - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_ctl.start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            if (r_cnt == CW'(DW)) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_quo <= mag;
            r_rem <= '0;
            r_div <= i_n;
            r_neg <= diff[DW-1];
            r_acc <= DW'(i_old);
        end else if (r_busy) begin
            if (r_cnt == CW'(DW)) begin
                // Apply the sign: this truncates toward zero.
                r_step <= r_neg ? DW'(-r_quo) : r_quo;
            end else begin
                r_quo <= {r_quo[DW-2:0], ge};
                r_rem <= ge ? trial_sub[RW-1:0] : trial[RW-1:0];
            end
        end else if (i_ctl.adv) begin
            r_acc <= r_acc + r_step;
        end
    end

    logic [DW-1:0] next_sum;
    assign next_sum = r_acc + r_step;
    assign o_next   = next_sum[POS_WIDTH-1:0];
    assign o_busy   = r_busy;

endmodule

[rtl/core/liu3_merge.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// liu3_merge
// Output register: gathers the three lane values, or the exact new
// position on the final item, together with the last flag.
// ----------------------------------------------------------------------------
module liu3_merge #(
    parameter int unsigned POS_WIDTH = 32
) (
    input  logic                                                i_clk,
    input  logic                                                i_rst_n,
    input  liu3_pkg::t_merge_ctl                                i_ctl,
    input  logic [liu3_pkg::NUM_AXES-1:0][POS_WIDTH-1:0]        i_lane_val,
    input  logic [liu3_pkg::NUM_AXES-1:0][POS_WIDTH-1:0]        i_final_val,
    input  logic                                                i_out_stall,
    output logic                                                o_free,
    output logic                                                o_out_valid,
    output logic [liu3_pkg::NUM_AXES-1:0][POS_WIDTH-1:0]        o_val,
    output logic                                                o_last
);

    logic                                          r_valid;
    logic [liu3_pkg::NUM_AXES-1:0][POS_WIDTH-1:0]  r_val;
    logic                                          r_last;

    // The register may be reloaded when empty or when its item leaves now.
    assign o_free = !r_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_ctl.load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_ctl.load) begin
            r_val  <= i_ctl.last ? i_final_val : i_lane_val;
            r_last <= i_ctl.last;
        end
    end

    assign o_out_valid = r_valid;
    assign o_val       = r_val;
    assign o_last      = r_last;

endmodule

[tb/liu3_track_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// liu3_track_checker
// Watches both channels and the register port of the upsampler, predicts the
// interpolated track for every accepted position and compares each result
// field by field with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module liu3_track_checker #(
    parameter int unsigned MAX_SAMPLES = 64,
    parameter int unsigned POS_WIDTH   = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_stall,
    input  logic signed [POS_WIDTH-1:0]   i_pos_x,
    input  logic signed [POS_WIDTH-1:0]   i_pos_y,
    input  logic signed [POS_WIDTH-1:0]   i_pos_z,
    input  logic                          i_out_valid,
    input  logic                          i_out_stall,
    input  logic signed [POS_WIDTH-1:0]   i_out_x,
    input  logic signed [POS_WIDTH-1:0]   i_out_y,
    input  logic signed [POS_WIDTH-1:0]   i_out_z,
    input  logic                          i_last_sample,
    input  logic                          i_cfg_we,
    input  logic [liu3_pkg::CFG_W-1:0]    i_cfg_data,
    output int                            o_fail_count,
    output int                            o_pending
);

    typedef logic signed [POS_WIDTH-1:0] t_pos;

    typedef struct {
        t_pos x;
        t_pos y;
        t_pos z;
        logic last;
    } t_track_sample;

    t_track_sample                 predicted_samples[$];
    logic [liu3_pkg::CFG_W-1:0]    samples_reg;
    t_pos                          held_x;
    t_pos                          held_y;
    t_pos                          held_z;
    int                            fail_total;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        fail_total   = 0;
        samples_reg  = liu3_pkg::CFG_RESET;
        held_x       = '0;
        held_y       = '0;
        held_z       = '0;
    end

    // Zero counts as one; anything above the ceiling is clamped to it.
    function automatic longint samples_in_force(input logic [liu3_pkg::CFG_W-1:0] raw);
        if (raw == '0)
            return 1;
        if (raw > MAX_SAMPLES)
            return MAX_SAMPLES;
        return longint'(raw);
    endfunction

    task automatic predict_track(input t_pos nx, input t_pos ny, input t_pos nz);
        longint        n;
        longint        step_x;
        longint        step_y;
        longint        step_z;
        t_track_sample s;
        n      = samples_in_force(samples_reg);
        // Signed division in SystemVerilog truncates toward zero.
        step_x = (longint'(nx) - longint'(held_x)) / n;
        step_y = (longint'(ny) - longint'(held_y)) / n;
        step_z = (longint'(nz) - longint'(held_z)) / n;
        for (longint k = 1; k < n; k++) begin
            s.x    = t_pos'(longint'(held_x) + k * step_x);
            s.y    = t_pos'(longint'(held_y) + k * step_y);
            s.z    = t_pos'(longint'(held_z) + k * step_z);
            s.last = 1'b0;
            predicted_samples.push_back(s);
        end
        s.x    = nx;
        s.y    = ny;
        s.z    = nz;
        s.last = 1'b1;
        predicted_samples.push_back(s);
        held_x = nx;
        held_y = ny;
        held_z = nz;
    endtask

    task automatic check_field(input string field, input logic signed [POS_WIDTH:0] want,
                               input logic signed [POS_WIDTH:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            fail_total++;
        end
    endtask

    always @(posedge i_clk) begin
        t_track_sample want;
        if (!i_rst_n) begin
            samples_reg = liu3_pkg::CFG_RESET;
            held_x      = '0;
            held_y      = '0;
            held_z      = '0;
            predicted_samples.delete();
        end else begin
            if (i_cfg_we)
                samples_reg = i_cfg_data;
            if (i_in_valid && !i_in_stall)
                predict_track(i_pos_x, i_pos_y, i_pos_z);
            if (i_out_valid && !i_out_stall) begin
                if (predicted_samples.size() == 0) begin
                    $error("unexpected result: x=%0d y=%0d z=%0d last=%0b",
                           i_out_x, i_out_y, i_out_z, i_last_sample);
                    fail_total++;
                end else begin
                    want = predicted_samples.pop_front();
                    check_field("out_x", want.x, i_out_x);
                    check_field("out_y", want.y, i_out_y);
                    check_field("out_z", want.z, i_out_z);
                    check_field("last_sample", want.last, i_last_sample);
                end
            end
        end
        // Published with nonblocking updates so that the stimulus side reads
        // settled values at every edge.
        o_pending    <= predicted_samples.size();
        o_fail_count <= fail_total;
    end

endmodule

[tb/tb_linear_interp_upsampler_3axis_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_linear_interp_upsampler_3axis_top
// Self-checking bench for the three-axis linear interpolation upsampler.
// ----------------------------------------------------------------------------
// A short directed run covers the position extremes, full-scale jumps in both
// directions and steps that truncate toward zero, then a sequence of phases
// changes the sample count (including zero, one, the ceiling and values above
// it) and sends random positions. The input idles and the output stalls at
// random; a separate checker predicts every result and counts mismatches.
// ----------------------------------------------------------------------------
module tb_linear_interp_upsampler_3axis_top;

    localparam int unsigned MAX_SAMPLES     = 64;
    localparam int unsigned POS_WIDTH       = 32;
    localparam int unsigned HOLD_OFF_CYCLES = 400;
    localparam int unsigned SETTLE_CYCLES   = 8;
    localparam int unsigned TAIL_CYCLES     = 48;
    localparam int unsigned IDLE_LIMIT      = 4000;

    typedef logic signed [POS_WIDTH-1:0] t_pos;

    localparam t_pos POS_MAX = {1'b0, {(POS_WIDTH-1){1'b1}}};
    localparam t_pos POS_MIN = {1'b1, {(POS_WIDTH-1){1'b0}}};

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        i_in_valid;
    logic                        o_in_stall;
    t_pos                        i_pos_x;
    t_pos                        i_pos_y;
    t_pos                        i_pos_z;
    logic                        o_out_valid;
    logic                        i_out_stall;
    t_pos                        o_out_x;
    t_pos                        o_out_y;
    t_pos                        o_out_z;
    logic                        o_last_sample;
    logic                        i_cfg_we;
    logic [liu3_pkg::CFG_W-1:0]  i_cfg_data;

    int                          fail_count;
    int                          pending_samples;

    // Set by the stimulus to ask the output side for one long hold-off.
    bit                          hold_off_req = 1'b0;

    // The most recent position handed to the block, per axis. Random items are
    // often drawn close to these so that small, truncating steps are common.
    t_pos                        sent_x;
    t_pos                        sent_y;
    t_pos                        sent_z;

    linear_interp_upsampler_3axis_top #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .POS_WIDTH   (POS_WIDTH)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_pos_x       (i_pos_x),
        .i_pos_y       (i_pos_y),
        .i_pos_z       (i_pos_z),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_x       (o_out_x),
        .o_out_y       (o_out_y),
        .o_out_z       (o_out_z),
        .o_last_sample (o_last_sample),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data)
    );

    liu3_track_checker #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .POS_WIDTH   (POS_WIDTH)
    ) u_track_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_stall    (o_in_stall),
        .i_pos_x       (i_pos_x),
        .i_pos_y       (i_pos_y),
        .i_pos_z       (i_pos_z),
        .i_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .i_out_x       (o_out_x),
        .i_out_y       (o_out_y),
        .i_out_z       (o_out_z),
        .i_last_sample (o_last_sample),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .o_fail_count  (fail_count),
        .o_pending     (pending_samples)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Offers one position and holds it until the block takes it. Valid is left
    // high on return, so a following item with no gap simply replaces the
    // payload and valid is never dropped and raised within one edge.
    task automatic send_position(input t_pos x, input t_pos y, input t_pos z);
        i_in_valid <= 1'b1;
        i_pos_x    <= x;
        i_pos_y    <= y;
        i_pos_z    <= z;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        sent_x = x;
        sent_y = y;
        sent_z = z;
    endtask

    task automatic pause_input(input int unsigned cycles);
        if (cycles > 0) begin
            i_in_valid <= 1'b0;
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    // Mostly no gap, often a short one and now and then a long one.
    function automatic int unsigned input_gap();
        int unsigned r;
        r = $urandom_range(0, 19);
        if (r < 12)
            return 0;
        if (r < 18)
            return $urandom_range(1, 4);
        return $urandom_range(20, 150);
    endfunction

    // The sender stops until every predicted result has come out. The first
    // edge lets the checker count an item accepted at the current edge.
    task automatic drain_block();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_samples != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_sample_count(input logic [liu3_pkg::CFG_W-1:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // One random axis value: fully random words, small moves from the last
    // value sent, the two extremes, or something near zero.
    function automatic t_pos random_axis(input t_pos from);
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 4)
            return t_pos'($urandom);
        if (r < 7)
            return t_pos'(int'(from) + int'($urandom_range(0, 4000)) - 2000);
        if (r == 7)
            return POS_MAX;
        if (r == 8)
            return POS_MIN;
        return t_pos'(int'($urandom_range(0, 256)) - 128);
    endfunction

    task automatic send_random_position();
        send_position(random_axis(sent_x), random_axis(sent_y), random_axis(sent_z));
    endtask

    // Output side. Stretches of free flow, stretches of scattered stalls and
    // stretches of stall bursts, mostly short but sometimes long, follow each
    // other at random. On request it holds off for a long, counted stretch.
    initial begin : output_side
        int unsigned stretch;
        int unsigned mode;
        int unsigned done;
        int unsigned burst;
        i_out_stall = 1'b0;
        forever begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                repeat (HOLD_OFF_CYCLES) begin
                    @(posedge i_clk);
                    i_out_stall <= 1'b1;
                end
            end else begin
                stretch = $urandom_range(1, 40);
                mode    = $urandom_range(0, 3);
                done    = 0;
                while (done < stretch) begin
                    if (mode == 3) begin
                        burst = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                                            : $urandom_range(1, 3);
                        repeat (burst) begin
                            @(posedge i_clk);
                            i_out_stall <= 1'b1;
                        end
                        @(posedge i_clk);
                        i_out_stall <= 1'b0;
                        done += burst + 1;
                    end else begin
                        @(posedge i_clk);
                        i_out_stall <= (mode != 0) && ($urandom_range(0, 3) == 0);
                        done++;
                    end
                end
            end
        end
    end

    // Watchdog: ends the run if neither channel moves an item for too long.
    // The bound covers the long hold-off, the longest input gap and a full
    // division pass several times over.
    initial begin : watchdog
        int unsigned quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("Regression FAIL");
        $finish;
    end

    initial begin : stimulus
        logic [liu3_pkg::CFG_W-1:0] count_setting;
        int unsigned                phase_items;
        bit                         gapless;

        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_pos_x    = '0;
        i_pos_y    = '0;
        i_pos_z    = '0;
        i_cfg_we   = 1'b0;
        i_cfg_data = '0;
        sent_x     = '0;
        sent_y     = '0;
        sent_z     = '0;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, at the sample count left by reset. The track starts
        // from the origin, so the first item checks the reset state.
        send_position('0, '0, '0);
        // Full-scale jumps: to the extremes, then straight across the range
        // in both directions, with small moves that truncate to a zero step.
        send_position(POS_MAX, POS_MIN, 7);
        send_position(POS_MIN, POS_MAX, -7);
        send_position(POS_MAX, POS_MIN, -1);
        pause_input(input_gap());
        // Negative differences truncate toward zero, not downwards.
        send_position(-1, 1, -9);
        send_position(1, -1, 8);
        send_position(32'h0001_0000, 32'hFFFF_0000, 32'h7FFF_FFF8);
        // An unchanged position gives a flat track.
        send_position(32'h0001_0000, 32'hFFFF_0000, 32'h7FFF_FFF8);
        send_position(32'hAAAA_AAAA, 32'h5555_5555, POS_MIN);
        send_position(32'h5555_5555, 32'hAAAA_AAAA, POS_MAX);
        send_position(-32'sd100, 32'sd100, 32'sd0);

        // Pressure: the output holds off for a long stretch while the input
        // keeps offering items back to back, so the block fills and stalls
        // its input. Afterwards the input waits until everything has drained.
        hold_off_req = 1'b1;
        repeat (6) send_random_position();
        drain_block();

        // Directed corners of the register: zero acts as one, one emits the
        // new position alone, the ceiling itself, and values above it clamp.
        write_sample_count(7'd0);
        send_position(POS_MIN, POS_MAX, 5);
        send_position(POS_MAX, POS_MIN, -5);
        drain_block();
        write_sample_count(7'd1);
        send_position(POS_MIN, 1, -1);
        drain_block();
        write_sample_count(7'd64);
        send_position(POS_MAX, POS_MIN, 63);
        send_position(POS_MIN, POS_MAX, -65);
        drain_block();
        write_sample_count(7'd127);
        send_position(POS_MAX, POS_MIN, 127);
        drain_block();
        write_sample_count(7'd65);
        send_position(POS_MIN, POS_MAX, -128);
        drain_block();

        // Random phases. Early phases revisit the corners; later ones favour
        // small counts, which keep the run short, with an occasional large or
        // clamped one. Every phase change happens with the block drained.
        for (int unsigned p = 0; p < 16; p++) begin
            unique case (p)
                0:       count_setting = 7'd1;
                1:       count_setting = 7'd64;
                2:       count_setting = 7'd0;
                3:       count_setting = 7'd127;
                4:       count_setting = 7'd2;
                default: count_setting = ($urandom_range(0, 4) == 0)
                                         ? 7'($urandom_range(13, 127))
                                         : 7'($urandom_range(1, 12));
            endcase
            write_sample_count(count_setting);
            phase_items = (count_setting >= 32) ? 8 : 30;
            gapless     = ($urandom_range(0, 3) == 0);
            for (int unsigned i = 0; i < phase_items; i++) begin
                send_random_position();
                if (!gapless)
                    pause_input(input_gap());
            end
            drain_block();
        end

        // Wait out the tail of the last item before giving the verdict.
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

[linear_interp_upsampler_3axis_top.f]
rtl/core/liu3_pkg.sv
rtl/core/liu3_lane.sv
rtl/core/liu3_merge.sv
rtl/core/linear_interp_upsampler_3axis_top.sv
tb/liu3_track_checker.sv
tb/tb_linear_interp_upsampler_3axis_top.sv
